### sv/sd_spi_block_read_receiver_assert.svh
// ----------------------------------------------------------------------------
// SD SPI block read receiver assertion macros
// Shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef SD_SPI_BLOCK_READ_RECEIVER_ASSERT_SVH
`define SD_SPI_BLOCK_READ_RECEIVER_ASSERT_SVH

// same-cycle implication
`define SDRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdrd assertion failed");

// next-cycle implication
`define SDRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdrd assertion failed");

`endif

### sv/sdrd_pkg.sv
// ----------------------------------------------------------------------------
// sdrd_pkg
// Types and constants for the SD SPI block read receiver
// ----------------------------------------------------------------------------
package sdrd_pkg;

  localparam int unsigned MAX_BLOCK_BYTES = 512;
  localparam int unsigned LEN_W           = 10;
  localparam int unsigned IDX_W           = 9;
  localparam int unsigned CLAMP_LEN       = (MAX_BLOCK_BYTES > 1023) ? 1023 : MAX_BLOCK_BYTES;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(512);
  localparam logic [LEN_W-1:0] LEN_CLAMP = LEN_W'(CLAMP_LEN);

  localparam logic [7:0] TOKEN_IDLE  = 8'hFF;
  localparam logic [7:0] TOKEN_START = 8'hFE;

  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_SINGLE = 2'd1;
  localparam logic [1:0] CMD_MULTI  = 2'd2;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_DATA = 2'd1,
    PH_CRC  = 2'd2,
    PH_END  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_WAIT    = 3'd0,
    ST_DATA    = 3'd1,
    ST_CRC     = 3'd2,
    ST_DONE    = 3'd3,
    ST_ERROR   = 3'd4,
    ST_STARTED = 3'd5
  } status_t;

  typedef struct packed {
    phase_t           phase;
    logic [LEN_W-1:0] byte_count;
    logic             crc_count;
    logic             multi_mode;
    logic             error_seen;
  } rd_state_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last_of_block;
  } rd_result_t;

endpackage

### sv/sdrd_step.sv
// ----------------------------------------------------------------------------
// sdrd_step
// Next-state and result logic for one received word
// ----------------------------------------------------------------------------
module sdrd_step (
  input  sdrd_pkg::rd_state_t               cur,
  input  logic [1:0]                        cmd,
  input  logic [7:0]                        rx_byte,
  input  logic [sdrd_pkg::LEN_W-1:0]        block_length,
  output sdrd_pkg::rd_state_t               nxt,
  output sdrd_pkg::rd_result_t              res
);
  import sdrd_pkg::*;

  logic [LEN_W-1:0] eff_len;
  logic [LEN_W:0]   cnt_inc;
  logic             at_last;
  status_t          end_status;

  always_comb begin
    if (block_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (block_length > LEN_CLAMP) begin
      eff_len = LEN_CLAMP;
    end else begin
      eff_len = block_length;
    end
  end

  assign cnt_inc    = {1'b0, cur.byte_count} + (LEN_W+1)'(1);
  assign at_last    = cnt_inc >= {1'b0, eff_len};
  assign end_status = cur.error_seen ? ST_ERROR : ST_DONE;

  // next state
  always_comb begin
    nxt = cur;
    unique case (cmd) inside
      CMD_SINGLE, CMD_MULTI: begin
        nxt.byte_count = '0;
        nxt.crc_count  = 1'b0;
        nxt.error_seen = 1'b0;
        nxt.multi_mode = (cmd == CMD_MULTI);
        nxt.phase      = PH_WAIT;
      end
      CMD_BYTE: begin
        unique case (cur.phase)
          PH_WAIT: begin
            if (rx_byte == TOKEN_START) begin
              nxt.phase      = PH_DATA;
              nxt.byte_count = '0;
            end else if (rx_byte != TOKEN_IDLE) begin
              nxt.error_seen = 1'b1;
              nxt.phase      = PH_END;
            end
          end
          PH_DATA: begin
            if (at_last) begin
              nxt.byte_count = '0;
              nxt.crc_count  = 1'b0;
              nxt.phase      = PH_CRC;
            end else begin
              nxt.byte_count = cnt_inc[LEN_W-1:0];
            end
          end
          PH_CRC: begin
            if (!cur.crc_count) begin
              nxt.crc_count = 1'b1;
            end else begin
              nxt.crc_count  = 1'b0;
              nxt.byte_count = '0;
              nxt.phase      = cur.multi_mode ? PH_WAIT : PH_END;
            end
          end
          PH_END: begin
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    res = '{status: ST_WAIT, data_byte: '0, byte_index: '0, last_of_block: 1'b0};
    unique case (cmd) inside
      CMD_SINGLE, CMD_MULTI: begin
        res.status = ST_STARTED;
      end
      CMD_BYTE: begin
        unique case (cur.phase)
          PH_WAIT: begin
            if (rx_byte != TOKEN_START && rx_byte != TOKEN_IDLE) begin
              res.status = ST_ERROR;
            end
          end
          PH_DATA: begin
            res.status        = ST_DATA;
            res.data_byte     = rx_byte;
            res.byte_index    = cur.byte_count[IDX_W-1:0];
            res.last_of_block = at_last;
          end
          PH_CRC: begin
            if (cur.crc_count) begin
              res.status = cur.multi_mode ? ST_CRC : ST_DONE;
            end
          end
          PH_END: begin
            res.status = end_status;
          end
          default: begin
          end
        endcase
      end
      default: begin
        if (cur.phase == PH_END) begin
          res.status = end_status;
        end
      end
    endcase
  end

endmodule

### sv/sdrd_out_q.sv
// ----------------------------------------------------------------------------
// sdrd_out_q
// Two-entry result queue between the receiver logic and the output port
// ----------------------------------------------------------------------------
module sdrd_out_q (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sdrd_pkg::rd_result_t  push_data,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sdrd_pkg::rd_result_t  out_data
);
  import sdrd_pkg::*;

  rd_result_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/sd_spi_block_read_receiver.sv
// ----------------------------------------------------------------------------
// sd_spi_block_read_receiver
// SD card SPI-mode data block read receiver
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one word per item: cmd starts a
// single or multi block read, or hands over rx_byte received from the card.
// Every accepted word yields exactly one result word on the output channel
// (out_valid / out_stall): status, data_byte, byte_index, last_of_block.
// The config channel (cfg_valid / cfg_ready) writes block_length; it is always
// ready and is meant to be used only while no word is in flight.
// Each result is registered in the result queue when its word is accepted.
// Throughput: one word per cycle while in_stall is low; the phase and counter
// update is a single pass of logic into the state registers and a two-entry
// result queue. When the receiver downstream stalls, the queue absorbs up to
// two results, then in_stall rises until a result is taken.
// Reset: the read is in the end phase (reports done), block_length is 512,
// the result queue is empty.
// ----------------------------------------------------------------------------
module sd_spi_block_read_receiver (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 cmd,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 status,
  output logic [7:0]                 data_byte,
  output logic [sdrd_pkg::IDX_W-1:0] byte_index,
  output logic                       last_of_block,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sdrd_pkg::LEN_W-1:0] block_length
);
  import sdrd_pkg::*;

  rd_state_t        state;
  rd_state_t        state_next;
  rd_result_t       step_res;
  rd_result_t       q_out;
  logic [LEN_W-1:0] blk_len;
  logic             q_full;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_len <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      blk_len <= block_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_END, byte_count: '0, crc_count: 1'b0,
                 multi_mode: 1'b0, error_seen: 1'b0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  sdrd_step u_step (
    .cur          (state),
    .cmd          (cmd),
    .rx_byte      (rx_byte),
    .block_length (blk_len),
    .nxt          (state_next),
    .res          (step_res)
  );

  sdrd_out_q u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (q_out)
  );

  assign status        = q_out.status;
  assign data_byte     = q_out.data_byte;
  assign byte_index    = q_out.byte_index;
  assign last_of_block = q_out.last_of_block;

endmodule

### sv/sdrd_check.sv
// ----------------------------------------------------------------------------
// sdrd_check
// Port-level checker for the SD SPI block read receiver
// ----------------------------------------------------------------------------
`include "sd_spi_block_read_receiver_assert.svh"

module sdrd_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic [7:0] data_byte,
  input logic [8:0] byte_index,
  input logic       last_of_block
);
  import sdrd_pkg::*;

  logic [20:0] out_word;
  logic        payload_zero;

  assign out_word     = {status, data_byte, byte_index, last_of_block};
  assign payload_zero = (data_byte == 8'd0) && (byte_index == '0) && !last_of_block;

  `SDRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `SDRD_ASSERT_NOW(a_payload_quiet, out_valid && status != ST_DATA, payload_zero)
  `SDRD_ASSERT_NOW(a_status_range, out_valid, status <= ST_STARTED)
  `SDRD_ASSERT_NOW(a_stall_when_full, in_stall, out_valid)
  `SDRD_ASSERT_NOW(a_empty_after_reset, $past(rst), !out_valid && !in_stall)

endmodule

bind sd_spi_block_read_receiver sdrd_check u_sdrd_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .data_byte     (data_byte),
  .byte_index    (byte_index),
  .last_of_block (last_of_block)
);

### tb/tb_sd_spi_block_read_receiver.sv
// ----------------------------------------------------------------------------
// tb_sd_spi_block_read_receiver
// Self-checking testbench for the SD SPI-mode block read receiver
// ----------------------------------------------------------------------------
// Words are driven on the falling clock edge and sampled on the rising edge.
// Each accepted input word runs through a cycle-free model of the receiver
// (wait/data/crc/end phases, clamped block length), and the predicted result
// word is queued. The checker compares every accepted output word field by
// field with the oldest queued result. Directed reads cover the reset state,
// single and multi block reads, bad tokens, the unused command and the
// length clamps. Random reads are mostly well formed with random data, mixed
// with noise and cut-off reads. Both sides idle at random, and a long
// receiver hold-off fills the result queue so the input stalls.
// ----------------------------------------------------------------------------
module tb_sd_spi_block_read_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import sdrd_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           cmd = CMD_BYTE;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           status;
  logic [7:0]           data_byte;
  logic [IDX_W-1:0]     byte_index;
  logic                 last_of_block;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [LEN_W-1:0]     block_length = '0;

  rd_state_t            recv_state;
  logic [LEN_W-1:0]     cfg_len;
  rd_result_t           pending_results[$];

  bit                   in_gaps = 1'b1;
  bit                   out_gaps = 1'b1;
  int                   hold_left = 0;
  int                   mismatch_count = 0;
  int                   words_sent = 0;
  int                   data_words = 0;
  int                   blocks_read = 0;
  int                   error_words = 0;
  int                   cfg_writes = 0;
  int                   input_stall_cycles = 0;

  sd_spi_block_read_receiver dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .data_byte     (data_byte),
    .byte_index    (byte_index),
    .last_of_block (last_of_block),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .block_length  (block_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("tb_sd_spi_block_read_receiver failed");
    $finish;
  end

  function automatic int eff_block_len(logic [LEN_W-1:0] v);
    int n;
    n = int'(v);
    if (n == 0) n = 1;
    if (n > int'(MAX_BLOCK_BYTES)) n = int'(MAX_BLOCK_BYTES);
    return n;
  endfunction

  function automatic rd_result_t predict_result(logic [1:0] c, logic [7:0] b);
    rd_result_t r;
    int         n;
    r = '0;
    r.status = ST_WAIT;
    n = eff_block_len(cfg_len);
    if (c == CMD_SINGLE || c == CMD_MULTI) begin
      recv_state.byte_count = '0;
      recv_state.crc_count = 1'b0;
      recv_state.error_seen = 1'b0;
      recv_state.multi_mode = (c == CMD_MULTI);
      recv_state.phase = PH_WAIT;
      r.status = ST_STARTED;
    end else if (c == CMD_UNUSED) begin
      if (recv_state.phase == PH_END) r.status = recv_state.error_seen ? ST_ERROR : ST_DONE;
    end else begin
      case (recv_state.phase)
        PH_WAIT: begin
          if (b == TOKEN_START) begin
            recv_state.phase = PH_DATA;
            recv_state.byte_count = '0;
          end else if (b != TOKEN_IDLE) begin
            recv_state.error_seen = 1'b1;
            recv_state.phase = PH_END;
            r.status = ST_ERROR;
          end
        end
        PH_DATA: begin
          r.status = ST_DATA;
          r.data_byte = b;
          r.byte_index = recv_state.byte_count[IDX_W-1:0];
          if (int'(recv_state.byte_count) + 1 >= n) begin
            r.last_of_block = 1'b1;
            recv_state.byte_count = '0;
            recv_state.crc_count = 1'b0;
            recv_state.phase = PH_CRC;
          end else begin
            recv_state.byte_count = recv_state.byte_count + 1'b1;
          end
        end
        PH_CRC: begin
          if (!recv_state.crc_count) begin
            recv_state.crc_count = 1'b1;
          end else begin
            recv_state.crc_count = 1'b0;
            recv_state.byte_count = '0;
            if (recv_state.multi_mode) begin
              recv_state.phase = PH_WAIT;
              r.status = ST_CRC;
            end else begin
              recv_state.phase = PH_END;
              r.status = ST_DONE;
            end
          end
        end
        default: begin
          r.status = recv_state.error_seen ? ST_ERROR : ST_DONE;
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic send_word(logic [1:0] c, logic [7:0] b);
    rd_result_t r;
    @(negedge clk);
    while (in_gaps && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = predict_result(c, b);
    pending_results.push_back(r);
    words_sent++;
    if (r.status == ST_DATA) data_words++;
    if (r.last_of_block) blocks_read++;
    if (r.status == ST_ERROR) error_words++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_block_length(logic [LEN_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    block_length <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_len = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver side: long hold-off first, then random stalls
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= out_gaps && ($urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk) begin
    rd_result_t want;
    if (!rst && in_valid && in_stall) input_stall_cycles++;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, status", 32'(status), 0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (data_byte !== want.data_byte)
          report_mismatch("data_byte", 32'(data_byte), 32'(want.data_byte));
        if (byte_index !== want.byte_index)
          report_mismatch("byte_index", 32'(byte_index), 32'(want.byte_index));
        if (last_of_block !== want.last_of_block)
          report_mismatch("last_of_block", 32'(last_of_block), 32'(want.last_of_block));
      end
    end
  end

  task automatic test_after_reset();
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_UNUSED, 8'hFF);
    send_word(CMD_BYTE, TOKEN_IDLE);
    drain();
  endtask

  task automatic test_single_block();
    write_block_length(LEN_W'(2));
    send_word(CMD_SINGLE, 8'h5A);
    send_word(CMD_BYTE, TOKEN_IDLE);
    send_word(CMD_BYTE, TOKEN_START);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'hFF);
    send_word(CMD_BYTE, 8'h12);
    send_word(CMD_BYTE, 8'h34);
    send_word(CMD_BYTE, 8'hFE);
    send_word(CMD_UNUSED, 8'h00);
    drain();
  endtask

  task automatic test_multi_block();
    // zero length behaves as one byte per block
    write_block_length('0);
    send_word(CMD_MULTI, 8'hFF);
    send_word(CMD_BYTE, TOKEN_IDLE);
    send_word(CMD_BYTE, TOKEN_START);
    send_word(CMD_BYTE, 8'hA5);
    send_word(CMD_BYTE, 8'h01);
    send_word(CMD_BYTE, 8'h02);
    send_word(CMD_BYTE, TOKEN_START);
    send_word(CMD_BYTE, 8'h5A);
    send_word(CMD_UNUSED, 8'h77);
    send_word(CMD_BYTE, 8'h03);
    send_word(CMD_BYTE, 8'h04);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h80);
    send_word(CMD_UNUSED, 8'h00);
    send_word(CMD_SINGLE, 8'h00);
    send_word(CMD_BYTE, 8'hFD);
    drain();
  endtask

  task automatic test_clamped_length();
    int n;
    write_block_length(LEN_W'(1023));
    n = eff_block_len(cfg_len);
    send_word(CMD_SINGLE, 8'h00);
    send_word(CMD_BYTE, TOKEN_START);
    repeat (n + 2) send_word(CMD_BYTE, 8'($urandom));
    drain();
  endtask

  task automatic test_backpressure();
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    write_block_length(LEN_W'(6));
    @(posedge clk);
    hold_left = 40;
    send_word(CMD_MULTI, 8'h00);
    repeat (2) begin
      send_word(CMD_BYTE, TOKEN_START);
      repeat (8) send_word(CMD_BYTE, 8'($urandom));
    end
    send_word(CMD_BYTE, 8'h42);
    drain();
    in_gaps = 1'b1;
    out_gaps = 1'b1;
  endtask

  task automatic test_random_reads();
    logic [9:0] seq[$];
    int         done_words;
    int         round;
    int         len;
    int         blocks;
    int         cut;
    int         pos;
    bit         multi;
    done_words = 0;
    round = 0;
    write_block_length(LEN_W'(1));
    while (done_words < 250) begin
      round++;
      in_gaps = !(round >= 5 && round < 13);
      out_gaps = in_gaps;
      if ($urandom_range(0, 5) == 0) begin
        write_block_length(LEN_W'($urandom_range(0, 12)));
      end else if ($urandom_range(0, 15) == 0) begin
        drain();
      end
      len = eff_block_len(cfg_len);
      seq.delete();
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 8))
          seq.push_back({2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))});
      end else begin
        multi = 1'($urandom_range(0, 1));
        seq.push_back({multi ? CMD_MULTI : CMD_SINGLE, 8'($urandom)});
        blocks = multi ? $urandom_range(1, 3) : 1;
        repeat (blocks) begin
          repeat ($urandom_range(0, 3)) seq.push_back({CMD_BYTE, TOKEN_IDLE});
          seq.push_back({CMD_BYTE, TOKEN_START});
          repeat (len + 2) seq.push_back({CMD_BYTE, 8'($urandom)});
        end
        case ($urandom_range(0, 2))
          0: seq.push_back({CMD_BYTE, 8'($urandom_range(0, 253))});
          1: seq.push_back({CMD_UNUSED, 8'($urandom)});
          default: ;
        endcase
        // cut-off or corrupted read
        if ($urandom_range(0, 99) < 15) begin
          cut = $urandom_range(1, seq.size());
          while (seq.size() > cut) void'(seq.pop_back());
          pos = $urandom_range(0, seq.size() - 1);
          seq[pos] = {seq[pos][9:8], 8'($urandom)};
        end
      end
      foreach (seq[i]) send_word(seq[i][9:8], seq[i][7:0]);
      done_words += seq.size();
    end
    drain();
  endtask

  initial begin
    recv_state = '{phase: PH_END, byte_count: '0, crc_count: 1'b0,
                   multi_mode: 1'b0, error_seen: 1'b0};
    cfg_len = LEN_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_single_block();
    test_multi_block();
    test_clamped_length();
    test_backpressure();
    test_random_reads();

    drain();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results left over", pending_results.size(), 0);
    $display("covered %0d words over %0d block length writes:",
             words_sent, cfg_writes);
    $display("  %0d data bytes, %0d blocks, %0d errors",
             data_words, blocks_read, error_words);
    $display("input held off for %0d cycles, %0d mismatches", input_stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_sd_spi_block_read_receiver passed");
    end else begin
      $display("tb_sd_spi_block_read_receiver failed");
    end
    $finish;
  end

endmodule
